// File: rtl/dedup_insert_record_table_core_defines.svh
// Assertion macros used by the core, which checks its own logic.
`ifndef DEDUP_INSERT_RECORD_TABLE_CORE_DEFINES_SVH
`define DEDUP_INSERT_RECORD_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the condition.
`define DIRT_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the condition.
`define DIRT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dirt_pkg.sv
package dirt_pkg;

	localparam int KEY_W = 21;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [2:0] KIND_FULL  = 3'd0;
	localparam logic [2:0] KIND_YEAR  = 3'd1;
	localparam logic [2:0] KIND_YM    = 3'd2;
	localparam logic [2:0] KIND_YS    = 3'd3;
	localparam logic [2:0] KIND_GRADE = 3'd4;

	localparam logic [2:0] RS_ADDED    = 3'd0;
	localparam logic [2:0] RS_DUP      = 3'd1;
	localparam logic [2:0] RS_FULL     = 3'd2;
	localparam logic [2:0] RS_REPLACED = 3'd3;
	localparam logic [2:0] RS_READ_OK  = 3'd4;
	localparam logic [2:0] RS_BAD_IDX  = 3'd5;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month_or_season;
		logic [4:0]  day;
	} key_t;

	typedef struct packed {
		logic        op;
		logic [11:0] year;
		logic [3:0]  month_or_season;
		logic [4:0]  day;
		logic [63:0] payload;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  slot;
		logic [8:0]  entry_total;
		logic [11:0] out_year;
		logic [3:0]  out_month_or_season;
		logic [4:0]  out_day;
		logic [63:0] out_payload;
	} rsp_t;

	function automatic logic [KEY_W-1:0] key_mask(input logic [2:0] kind);
		logic [KEY_W-1:0] m;
		unique case (kind) inside
			KIND_YEAR:       m = {12'hFFF, 4'h0, 5'h00};
			KIND_YM, KIND_YS: m = {12'hFFF, 4'hF, 5'h00};
			default:         m = {12'hFFF, 4'hF, 5'h1F};
		endcase
		return m;
	endfunction

endpackage

// File: rtl/dedup_insert_record_table_core.sv
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  req (dirt_pkg::req_t)
// response  out        rsp_valid / rsp_ready  rsp (dirt_pkg::rsp_t)
// config    in         cfg_wr_en              cfg_wr_data (record kind)
//
// An insert without a match compares every stored entry, and one that matches entry i
// stops there: one key compare per stored entry on a single comparator, fed one entry
// per cycle from the table memory read port.
// A read goes through S_READ to S_DONE; a kind 4 insert or a bad index skips to S_DONE.
// Reset empties the table at once; no clearing pass is needed.
// A waiting response holds the block in its final state until it is taken.
`include "dedup_insert_record_table_core_defines.svh"

module dedup_insert_record_table_core #(
	parameter int ENTRIES       = 256,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dirt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dirt_pkg::rsp_t rsp,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_wr_data
);

	import dirt_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int MEM_W = KEY_W + PAYLOAD_WIDTH;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_DONE} state_t;

	state_t                  state_q;
	logic [2:0]              kind_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        issue_q;
	logic                    pend_s1;
	logic [CNT_W-1:0]        pidx_s1;
	req_t                    req_q;
	rsp_t                    res_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	logic                    req_fire;
	logic                    issue_more;
	logic                    hit;
	logic                    scan_end;
	logic                    append_go;
	logic                    grade_go;
	logic                    done_go;
	logic                    idx_ok;
	rsp_t                    first_res;
	rsp_t                    done_rsp;
	logic [IDX_W+7:0]        ridx_w;
	logic [IDX_W-1:0]        ram_raddr;
	logic [IDX_W-1:0]        ram_waddr;
	logic                    ram_we;
	logic [MEM_W-1:0]        ram_wdata;
	logic [MEM_W-1:0]        ram_rdata;
	key_t                    rd_key;
	logic [PAYLOAD_WIDTH-1:0] rd_pay;
	logic [PAYLOAD_WIDTH+63:0] rd_pay_w;
	logic [KEY_W-1:0]        req_key;

	function automatic logic [7:0] to_slot(input logic [CNT_W-1:0] v);
		logic [CNT_W+7:0] w;
		w = {8'b0, v};
		return w[7:0];
	endfunction

	function automatic logic [8:0] to_total(input logic [CNT_W-1:0] v);
		logic [CNT_W+8:0] w;
		w = {9'b0, v};
		return w[8:0];
	endfunction

	dirt_ram #(
		.WIDTH(MEM_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready  = (state_q == S_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign ridx_w     = {{IDX_W{1'b0}}, req.read_index};
	assign idx_ok     = ({{CNT_W{1'b0}}, req.read_index} < {8'b0, count_q});
	assign req_key    = {req_q.year, req_q.month_or_season, req_q.day};
	assign rd_key     = ram_rdata[MEM_W-1 -: KEY_W];
	assign rd_pay     = ram_rdata[PAYLOAD_WIDTH-1:0];
	assign rd_pay_w   = {64'b0, rd_pay};

	assign issue_more = (issue_q < count_q);
	assign hit        = pend_s1 && (((rd_key ^ req_key) & key_mask(kind_q)) == '0);
	assign scan_end   = (state_q == S_SCAN) && !hit && !issue_more && !pend_s1;
	assign append_go  = scan_end && (count_q != CNT_W'(ENTRIES));
	assign grade_go   = req_fire && (req.op == OP_INSERT) && (kind_q == KIND_GRADE);
	assign done_go    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign ram_raddr  = (state_q == S_IDLE) ? ridx_w[IDX_W-1:0] : issue_q[IDX_W-1:0];
	assign ram_we     = grade_go || append_go;
	assign ram_waddr  = grade_go ? '0 : count_q[IDX_W-1:0];
	assign ram_wdata  = grade_go
		? {req.year, req.month_or_season, req.day, req.payload[PAYLOAD_WIDTH-1:0]}
		: {req_key, req_q.payload[PAYLOAD_WIDTH-1:0]};

	always_comb begin
		first_res      = '0;
		first_res.slot = req.read_index;
		if (req.op == OP_READ) begin
			first_res.status = idx_ok ? RS_READ_OK : RS_BAD_IDX;
		end else begin
			first_res.status = RS_REPLACED;
			first_res.slot   = '0;
		end
	end

	always_comb begin
		done_rsp             = res_q;
		done_rsp.entry_total = to_total(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_FULL;
			count_q     <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				kind_q <= cfg_wr_data;
			end
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						issue_q <= '0;
						pend_s1 <= 1'b0;
						if (req.op == OP_READ) begin
							state_q <= idx_ok ? S_READ : S_DONE;
						end else if (kind_q == KIND_GRADE) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit || scan_end) begin
						state_q <= S_DONE;
						if (append_go) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						pend_s1 <= issue_more;
						pidx_s1 <= issue_q;
						if (issue_more) begin
							issue_q <= issue_q + 1'b1;
						end
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_go) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The request, the pending result and the response carry no control state.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
			res_q <= first_res;
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				{res_q.status, res_q.slot} <= {RS_DUP, to_slot(pidx_s1)};
			end else if (append_go) begin
				{res_q.status, res_q.slot} <= {RS_ADDED, to_slot(count_q)};
			end else if (scan_end) begin
				res_q.status <= RS_FULL;
			end
		end else if (state_q == S_READ) begin
			{res_q.out_year, res_q.out_month_or_season, res_q.out_day, res_q.out_payload}
				<= {rd_key, rd_pay_w[63:0]};
		end
		if (done_go) begin
			rsp_q <= done_rsp;
		end
	end

	`DIRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRIES), "Count above size.")
	`DIRT_ASSERT_NEXT(a_append_step, append_go, count_q == $past(count_q) + 1'b1, "Bad append.")
	`DIRT_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "Request taken while busy.")
	`DIRT_ASSERT_NOW(a_idle_payload, rsp_valid && (rsp.status != RS_READ_OK), rsp.out_payload == 64'b0, "Stray payload.")

endmodule

// File: rtl/dirt_ram.sv
module dirt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: dv/record_table_checker.sv
`timescale 1ns / 100ps

module record_table_checker #(
	parameter int ENTRIES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  dirt_pkg::req_t   req,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  dirt_pkg::rsp_t   rsp,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_wr_data,
	output int               mismatches,
	output int               awaited,
	output int               stored,
	output logic [5:0][31:0] status_tally
);
	import dirt_pkg::*;

	key_t        key_mem  [ENTRIES];
	logic [63:0] data_mem [ENTRIES];
	logic [8:0]  fill;
	logic [2:0]  kind;
	rsp_t        awaited_rsp [$];

	task automatic apply_to_table(input req_t r, output rsp_t e);
		key_t        k;
		logic [20:0] care;
		int          hit;
		int          i;
		k.year = r.year;
		k.month_or_season = r.month_or_season;
		k.day = r.day;
		e = '0;
		if (r.op == OP_READ) begin
			e.slot = r.read_index;
			if ({1'b0, r.read_index} < fill) begin
				e.status = RS_READ_OK;
				e.out_year = key_mem[r.read_index].year;
				e.out_month_or_season = key_mem[r.read_index].month_or_season;
				e.out_day = key_mem[r.read_index].day;
				e.out_payload = data_mem[r.read_index];
			end else begin
				e.status = RS_BAD_IDX;
			end
		end else if (kind == KIND_GRADE) begin
			key_mem[0] = k;
			data_mem[0] = r.payload;
			e.status = RS_REPLACED;
			e.slot = '0;
		end else begin
			case (kind)
				KIND_YEAR: begin
					care = {12'hFFF, 9'h000};
				end
				KIND_YM, KIND_YS: begin
					care = {16'hFFFF, 5'h00};
				end
				default: begin
					care = '1;
				end
			endcase
			hit = -1;
			for (i = 0; i < int'(fill); i++) begin
				if (hit < 0 && ((key_mem[i] ^ k) & care) == '0) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				e.status = RS_DUP;
				e.slot = hit[7:0];
			end else if (int'(fill) == ENTRIES) begin
				e.status = RS_FULL;
				e.slot = '0;
			end else begin
				key_mem[fill] = k;
				data_mem[fill] = r.payload;
				e.status = RS_ADDED;
				e.slot = fill[7:0];
				fill = fill + 9'd1;
			end
		end
		e.entry_total = fill;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			fill = '0;
			kind = KIND_FULL;
			awaited_rsp.delete();
			mismatches = 0;
			status_tally = '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("Response with no request outstanding: status %0d slot %0d",
						rsp.status, rsp.slot);
					mismatches++;
				end else begin
					want = awaited_rsp.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("slot", want.slot, rsp.slot);
					compare_field("entry_total", want.entry_total, rsp.entry_total);
					compare_field("out_year", want.out_year, rsp.out_year);
					compare_field("out_month_or_season", want.out_month_or_season,
						rsp.out_month_or_season);
					compare_field("out_day", want.out_day, rsp.out_day);
					compare_field("out_payload", want.out_payload, rsp.out_payload);
					if (want.status <= RS_BAD_IDX) begin
						status_tally[want.status] = status_tally[want.status] + 32'd1;
					end
				end
			end
			if (req_valid && req_ready) begin
				apply_to_table(req, want);
				awaited_rsp.push_back(want);
			end
			if (cfg_wr_en) begin
				kind = cfg_wr_data;
			end
		end
		awaited = awaited_rsp.size();
		stored = int'(fill);
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import dirt_pkg::*;

	localparam int ENTRIES         = 256;
	localparam int CYCLE_LIMIT     = 1500000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASES          = 12;
	localparam int PHASE_ITEMS     = 90;

	localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
	localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

	localparam logic [PHASES-1:0][2:0] PLAN = {
		KIND_FULL, KIND_YEAR, KIND_YS, KIND_UNUSED_5, KIND_YM, KIND_GRADE,
		KIND_FULL, KIND_UNUSED_6, KIND_YEAR, KIND_YM, KIND_UNUSED_7, KIND_FULL
	};

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_wr_en;
	logic [2:0]       cfg_wr_data;
	int               mismatches;
	int               awaited;
	int               stored;
	logic [5:0][31:0] status_tally;

	logic calm;
	logic hold_off_ask;
	int   cycles;
	int   sent;
	int   kind_writes;
	key_t used_keys [$];

	dedup_insert_record_table_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	record_table_checker #(
		.ENTRIES (ENTRIES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.stored       (stored),
		.status_tally (status_tally)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Cycle limit reached with %0d responses outstanding.", awaited);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : response_side
		logic level;
		int   span;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_ask) begin
				hold_off_ask = 1'b0;
				level = 1'b0;
				span = HOLD_OFF_CYCLES;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				level = 1'b0;
				span = $urandom_range(1, 16);
			end else begin
				level = 1'b1;
				span = $urandom_range(1, 24);
			end
			rsp_ready <= level;
			repeat (span) @(negedge clk);
		end
	end

	function automatic key_t random_key();
		key_t k;
		k.year = 12'($urandom_range(0, 4095));
		k.month_or_season = 4'($urandom_range(0, 12));
		k.day = 5'($urandom_range(0, 31));
		return k;
	endfunction

	function automatic req_t read_of(input logic [7:0] idx);
		req_t r;
		r.op = OP_READ;
		r.year = 12'($urandom);
		r.month_or_season = 4'($urandom_range(0, 12));
		r.day = 5'($urandom);
		r.payload = {$urandom, $urandom};
		r.read_index = idx;
		return r;
	endfunction

	task automatic issue(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sent++;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	task automatic offer_insert(input key_t k, input logic [63:0] pay);
		req_t r;
		r.op = OP_INSERT;
		r.year = k.year;
		r.month_or_season = k.month_or_season;
		r.day = k.day;
		r.payload = pay;
		r.read_index = 8'($urandom);
		used_keys.push_back(k);
		issue(r);
	endtask

	task automatic set_kind(input logic [2:0] k);
		req_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= k;
		kind_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		key_t       lo;
		key_t       hi;
		key_t       k;
		logic [7:0] idx;
		int         p;
		int         n;
		int         pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = KIND_FULL;
		calm = 1'b0;
		hold_off_ask = 1'b0;
		sent = 0;
		kind_writes = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		lo = '0;
		hi.year = 12'hFFF;
		hi.month_or_season = 4'd12;
		hi.day = 5'd31;

		set_kind(KIND_FULL);
		issue(read_of(8'd0));
		issue(read_of(8'hFF));
		set_kind(KIND_GRADE);
		k.year = 12'd7;
		k.month_or_season = 4'd3;
		k.day = 5'd9;
		offer_insert(k, 64'h0123_4567_89AB_CDEF);
		issue(read_of(8'd0));
		set_kind(KIND_FULL);
		offer_insert(lo, 64'd0);
		offer_insert(hi, '1);
		offer_insert(lo, '1);
		k = lo;
		k.day = 5'd1;
		offer_insert(k, 64'h8000_0000_0000_0001);
		issue(read_of(8'd0));
		issue(read_of(8'd1));
		issue(read_of(8'd3));
		issue(read_of(8'hFF));
		set_kind(KIND_YEAR);
		k = hi;
		k.month_or_season = 4'd1;
		k.day = 5'd0;
		offer_insert(k, 64'h5555_5555_5555_5555);
		k.year = 12'd2048;
		offer_insert(k, 64'hAAAA_AAAA_AAAA_AAAA);
		set_kind(KIND_YM);
		k = hi;
		k.day = 5'd0;
		offer_insert(k, 64'h1);
		k.month_or_season = 4'd11;
		offer_insert(k, 64'h2);
		set_kind(KIND_YS);
		k = lo;
		k.day = 5'd20;
		offer_insert(k, 64'h3);
		set_kind(KIND_UNUSED_7);
		offer_insert(lo, 64'h4);
		k = lo;
		k.day = 5'd30;
		offer_insert(k, 64'h5);
		set_kind(KIND_GRADE);
		offer_insert(hi, 64'hFEDC_BA98_7654_3210);
		issue(read_of(8'd0));

		for (p = 0; p < PHASES; p++) begin
			set_kind(PLAN[PHASES - 1 - p]);
			calm = (p == PHASES - 1);
			if (p == 2) begin
				hold_off_ask = 1'b1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					if (stored > 0 && pick < 20) begin
						idx = 8'($urandom_range(0, stored - 1));
					end else begin
						idx = 8'($urandom_range(0, 255));
					end
					issue(read_of(idx));
				end else begin
					if (used_keys.size() > 0 && pick < 60) begin
						k = used_keys[$urandom_range(0, used_keys.size() - 1)];
						pick = $urandom_range(0, 2);
						if (pick == 1) begin
							k.day = 5'($urandom_range(0, 31));
						end else if (pick == 2) begin
							k.month_or_season = 4'($urandom_range(0, 12));
						end
					end else begin
						k = random_key();
					end
					offer_insert(k, {$urandom, $urandom});
				end
			end
		end

		req_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (16) @(negedge clk);

		$display("Sent %0d requests under %0d record-kind settings; table ended with %0d entries.",
			sent, kind_writes, stored);
		$display("Responses: %0d added, %0d duplicate, %0d full, %0d replaced, %0d read, %0d bad index.",
			status_tally[RS_ADDED], status_tally[RS_DUP], status_tally[RS_FULL],
			status_tally[RS_REPLACED], status_tally[RS_READ_OK], status_tally[RS_BAD_IDX]);
		if (mismatches == 0 && awaited == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
